@@ rtl/core/kst_pkg.sv @@
// shared constants and types for the keyed status table
package kst_pkg;

	localparam int ENTRIES  = 16;
	localparam int KEY_BITS = 64;
	localparam int IDX_W    = $clog2(ENTRIES);
	localparam int CNT_W    = $clog2(ENTRIES + 1);

	typedef enum logic {
		FUNC_SET    = 1'b0,
		FUNC_LOOKUP = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		RC_OK        = 2'd0,
		RC_FULL      = 2'd1,
		RC_NOT_FOUND = 2'd2
	} code_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [31:0]         addr;
		logic [15:0]         port;
		logic                flag;
	} entry_t;

endpackage

@@ rtl/core/kst_if.sv @@
// request and response channel interfaces for the keyed status table
interface kst_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [63:0] key;
	logic        online;
	logic [31:0] ip_addr;
	logic [15:0] port_num;

	modport source (output valid, func, key, online, ip_addr, port_num, input ready);
	modport sink (input valid, func, key, online, ip_addr, port_num, output ready);
endinterface

interface kst_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_code;
	logic [31:0] found_ip;
	logic [15:0] found_port;
	logic        found_online;

	modport source (output valid, result_code, found_ip, found_port, found_online, input ready);
	modport sink (input valid, result_code, found_ip, found_port, found_online, output ready);
endinterface

@@ rtl/core/keyed_status_table.sv @@
// keyed status table: sequential key search over a record memory with one read port
//
// usage:
//   req carries one request per transaction: func selects set (store online,
//   ip_addr and port_num under key) or lookup (return the stored record).
//   rsp carries one result per request: result_code is ok, table full (set of
//   a new key with every entry used) or not found (lookup miss); the found_*
//   fields hold the record on a lookup hit and are zero otherwise.
// timing:
//   a request is taken only while no other request is in progress. the search
//   reads one record per cycle from the memory, stopping at the first match.
//   requests are processed one at a time.
// reset:
//   arst_n empties the table (fill count to zero); no clearing pass is needed,
//   since entries at or above the fill count are never compared.
// stall:
//   the result sits in an output register; a new request may be accepted while
//   it waits. a finished request holds in its last step until the output
//   register is free, and only then commits its write.
module keyed_status_table (
	input  logic           clk,
	input  logic           arst_n,
	kst_req_if.sink        req,
	kst_rsp_if.source      rsp
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t state_q;

	// captured request
	kst_pkg::func_t                  func_q;
	logic [kst_pkg::KEY_BITS-1:0]    key_q;
	logic                            online_q;
	logic [31:0]                     ip_q;
	logic [15:0]                     port_q;

	logic [kst_pkg::CNT_W-1:0]       fill_q;
	logic [kst_pkg::CNT_W-1:0]       idx_q;

	// search pipeline
	logic                            rd_vld_s1;
	logic [kst_pkg::IDX_W-1:0]       rd_idx_s1;
	kst_pkg::entry_t                 rd_data_s1;

	logic                            hit_q;
	logic [kst_pkg::IDX_W-1:0]       hit_idx_q;
	kst_pkg::entry_t                 hit_data_q;

	// output register
	logic                            out_vld_q;
	kst_pkg::code_t                  code_q;
	logic [31:0]                     found_ip_q;
	logic [15:0]                     found_port_q;
	logic                            found_online_q;

	kst_pkg::entry_t                 mem_q [kst_pkg::ENTRIES];

	logic                            issue;
	logic                            match;
	logic                            out_free;
	logic                            full;
	logic                            commit;
	logic                            wr_en;
	logic [kst_pkg::IDX_W-1:0]       wr_addr;
	kst_pkg::entry_t                 wr_data;
	logic [kst_pkg::IDX_W-1:0]       rd_addr;

	assign issue    = (state_q == ST_SCAN) && (idx_q < fill_q);
	assign rd_addr  = idx_q[kst_pkg::IDX_W-1:0];
	assign match    = rd_vld_s1 && (rd_data_s1.key == key_q);
	assign out_free = !out_vld_q || rsp.ready;
	assign full     = !hit_q && (fill_q == kst_pkg::CNT_W'(kst_pkg::ENTRIES));
	assign commit   = (state_q == ST_FINISH) && out_free;
	assign wr_en    = commit && (func_q == kst_pkg::FUNC_SET) && !full;
	assign wr_addr  = hit_q ? hit_idx_q : fill_q[kst_pkg::IDX_W-1:0];

	always_comb begin
		wr_data.key  = key_q;
		wr_data.addr = ip_q;
		wr_data.port = port_q;
		wr_data.flag = online_q;
	end

	// record memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_s1 <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			func_q         <= kst_pkg::FUNC_SET;
			key_q          <= '0;
			online_q       <= 1'b0;
			ip_q           <= '0;
			port_q         <= '0;
			fill_q         <= '0;
			idx_q          <= '0;
			rd_vld_s1      <= 1'b0;
			rd_idx_s1      <= '0;
			hit_q          <= 1'b0;
			hit_idx_q      <= '0;
			hit_data_q     <= '0;
			out_vld_q      <= 1'b0;
			code_q         <= kst_pkg::RC_OK;
			found_ip_q     <= '0;
			found_port_q   <= '0;
			found_online_q <= 1'b0;
		end else begin
			if (commit) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						func_q    <= kst_pkg::func_t'(req.func);
						key_q     <= req.key[kst_pkg::KEY_BITS-1:0];
						online_q  <= req.online;
						ip_q      <= req.ip_addr;
						port_q    <= req.port_num;
						idx_q     <= '0;
						hit_q     <= 1'b0;
						rd_vld_s1 <= 1'b0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					rd_vld_s1 <= issue && !match;
					rd_idx_s1 <= rd_addr;
					if (issue) begin
						idx_q <= idx_q + kst_pkg::CNT_W'(1);
					end
					if (match) begin
						hit_q      <= 1'b1;
						hit_idx_q  <= rd_idx_s1;
						hit_data_q <= rd_data_s1;
						state_q    <= ST_FINISH;
					end else if (!issue && !rd_vld_s1) begin
						// every filled entry compared, no match
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						if (func_q == kst_pkg::FUNC_SET) begin
							code_q         <= full ? kst_pkg::RC_FULL : kst_pkg::RC_OK;
							found_ip_q     <= '0;
							found_port_q   <= '0;
							found_online_q <= 1'b0;
							if (!full && !hit_q) begin
								fill_q <= fill_q + kst_pkg::CNT_W'(1);
							end
						end else if (hit_q) begin
							code_q         <= kst_pkg::RC_OK;
							found_ip_q     <= hit_data_q.addr;
							found_port_q   <= hit_data_q.port;
							found_online_q <= hit_data_q.flag;
						end else begin
							code_q         <= kst_pkg::RC_NOT_FOUND;
							found_ip_q     <= '0;
							found_port_q   <= '0;
							found_online_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req.ready        = (state_q == ST_IDLE);
	assign rsp.valid        = out_vld_q;
	assign rsp.result_code  = code_q;
	assign rsp.found_ip     = found_ip_q;
	assign rsp.found_port   = found_port_q;
	assign rsp.found_online = found_online_q;

endmodule

@@ verif/tb_top.sv @@
// self-checking testbench for the keyed status table: set and lookup requests against a predictor
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int TAIL_CYCLES  = 4 * (kst_pkg::ENTRIES + 3);
	localparam int RANDOM_ITEMS = 310;

	localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - kst_pkg::KEY_BITS);

	typedef struct {
		kst_pkg::func_t func;
		logic [63:0]    key;
		logic           online;
		logic [31:0]    ip;
		logic [15:0]    port;
	} request_t;

	typedef struct {
		kst_pkg::code_t code;
		logic [31:0]    ip;
		logic [15:0]    port;
		logic           online;
	} status_rsp_t;

	logic clk;
	logic arst_n;

	kst_req_if req_ch ();
	kst_rsp_if rsp_ch ();

	keyed_status_table uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	request_t    request_queue[$];
	status_rsp_t pending_results[$];
	logic [63:0] stored_keys[$];

	// predictor copy of the table
	logic [kst_pkg::KEY_BITS-1:0] rec_key  [kst_pkg::ENTRIES];
	logic [31:0]                  rec_addr [kst_pkg::ENTRIES];
	logic [15:0]                  rec_port [kst_pkg::ENTRIES];
	logic                         rec_flag [kst_pkg::ENTRIES];
	int                           rec_fill;

	int tx_idle_pct;
	int rx_idle_pct;
	int errors;
	int cycles;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func = 1'b0;
		req_ch.key = '0;
		req_ch.online = 1'b0;
		req_ch.ip_addr = '0;
		req_ch.port_num = '0;
		rsp_ch.ready = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
	endtask

	// search, then update or append; returns the response the table should give
	function automatic status_rsp_t apply_request(request_t r);
		status_rsp_t                  res;
		int                           hit;
		logic [kst_pkg::KEY_BITS-1:0] k;
		k = r.key[kst_pkg::KEY_BITS-1:0];
		hit = -1;
		for (int i = 0; i < rec_fill; i++) begin
			if (hit < 0 && rec_key[i] == k)
				hit = i;
		end
		res.code = kst_pkg::RC_OK;
		res.ip = '0;
		res.port = '0;
		res.online = 1'b0;
		if (r.func == kst_pkg::FUNC_SET) begin
			if (hit < 0 && rec_fill < kst_pkg::ENTRIES) begin
				hit = rec_fill;
				rec_key[hit] = k;
				rec_fill++;
			end
			if (hit < 0) begin
				res.code = kst_pkg::RC_FULL;
			end else begin
				rec_flag[hit] = r.online;
				rec_addr[hit] = r.ip;
				rec_port[hit] = r.port;
			end
		end else if (hit < 0) begin
			res.code = kst_pkg::RC_NOT_FOUND;
		end else begin
			res.ip = rec_addr[hit];
			res.port = rec_port[hit];
			res.online = rec_flag[hit];
		end
		return res;
	endfunction

	task automatic queue_request(kst_pkg::func_t f, logic [63:0] k, logic on,
			logic [31:0] ip, logic [15:0] port);
		request_t r;
		bit       known;
		r.func = f;
		r.key = k;
		r.online = on;
		r.ip = ip;
		r.port = port;
		request_queue.push_back(r);
		// keep track of which keys the generator has put into the table
		known = 1'b0;
		foreach (stored_keys[i])
			if ((stored_keys[i] & KEY_MASK) == (k & KEY_MASK))
				known = 1'b1;
		if (f == kst_pkg::FUNC_SET && !known && stored_keys.size() < kst_pkg::ENTRIES)
			stored_keys.push_back(k);
	endtask

	function automatic logic [63:0] pick_key();
		int          r;
		int          b;
		logic [63:0] k;
		r = $urandom_range(99);
		if (stored_keys.size() != 0 && r < 75) begin
			k = stored_keys[$urandom_range(stored_keys.size() - 1)];
			// near miss: one bit away from a stored key
			if (r >= 60) begin
				b = $urandom_range(63);
				k[b] = ~k[b];
			end
		end else if (r < 82) begin
			case ($urandom_range(2))
				0: k = '0;
				1: k = '1;
				default: k = 64'd1 << $urandom_range(63);
			endcase
		end else begin
			k = {$urandom, $urandom};
		end
		return k;
	endfunction

	function automatic logic [31:0] pick_word();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom;
	endfunction

	task automatic queue_random_request();
		logic [31:0] w;
		w = pick_word();
		queue_request(kst_pkg::func_t'($urandom_range(1)), pick_key(),
				1'($urandom_range(1)), pick_word(), w[15:0]);
	endtask

	task automatic wait_drained();
		while (request_queue.size() != 0 || req_ch.valid || pending_results.size() != 0)
			@(negedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin : drive_proc
		request_t acc;
		request_t nxt;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.func <= 1'b0;
			req_ch.key <= '0;
			req_ch.online <= 1'b0;
			req_ch.ip_addr <= '0;
			req_ch.port_num <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				acc.func = kst_pkg::func_t'(req_ch.func);
				acc.key = req_ch.key;
				acc.online = req_ch.online;
				acc.ip = req_ch.ip_addr;
				acc.port = req_ch.port_num;
				pending_results.push_back(apply_request(acc));
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (request_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					nxt = request_queue.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.func <= nxt.func;
					req_ch.key <= nxt.key;
					req_ch.online <= nxt.online;
					req_ch.ip_addr <= nxt.ip;
					req_ch.port_num <= nxt.port;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin : monitor_proc
		status_rsp_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected transaction, code",
							64'(rsp_ch.result_code), '0);
				end else begin
					want = pending_results.pop_front();
					if (rsp_ch.result_code !== want.code)
						report_mismatch("result_code", 64'(rsp_ch.result_code),
								64'(want.code));
					if (rsp_ch.found_ip !== want.ip)
						report_mismatch("found_ip", 64'(rsp_ch.found_ip), 64'(want.ip));
					if (rsp_ch.found_port !== want.port)
						report_mismatch("found_port", 64'(rsp_ch.found_port),
								64'(want.port));
					if (rsp_ch.found_online !== want.online)
						report_mismatch("found_online", 64'(rsp_ch.found_online),
								64'(want.online));
				end
			end
			rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		rec_fill = 0;
		tx_idle_pct = 25;
		rx_idle_pct = 59;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// empty table, extreme keys and fields, update in place, then fill up to full
		queue_request(kst_pkg::FUNC_LOOKUP, 64'd5, 1'b1, '1, '1);
		queue_request(kst_pkg::FUNC_SET, '0, 1'b1, '1, '1);
		queue_request(kst_pkg::FUNC_SET, '1, 1'b0, '0, '0);
		queue_request(kst_pkg::FUNC_LOOKUP, '0, 1'b0, '0, '0);
		queue_request(kst_pkg::FUNC_LOOKUP, '1, 1'b1, '1, '1);
		queue_request(kst_pkg::FUNC_LOOKUP, 64'd1, 1'b0, '0, '0);
		queue_request(kst_pkg::FUNC_LOOKUP, 64'h7fff_ffff_ffff_ffff, 1'b0, '0, '0);
		queue_request(kst_pkg::FUNC_SET, '0, 1'b0, 32'h1234_5678, 16'habcd);
		queue_request(kst_pkg::FUNC_LOOKUP, '0, 1'b1, '0, '0);
		for (int i = 0; i < kst_pkg::ENTRIES - 2; i++)
			queue_request(kst_pkg::FUNC_SET, {$urandom, $urandom}, 1'($urandom_range(1)),
					$urandom, 16'($urandom_range(16'hffff)));
		queue_request(kst_pkg::FUNC_SET, 64'h8000_0000_0000_0000, 1'b1, '1, '1);
		queue_request(kst_pkg::FUNC_LOOKUP, 64'h8000_0000_0000_0000, 1'b0, '0, '0);
		wait_drained();

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					tx_idle_pct = 25;
					rx_idle_pct = 59;
				end
				1: begin
					tx_idle_pct = 59;
					rx_idle_pct = 25;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < RANDOM_ITEMS; n++)
				queue_random_request();
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
